[rtl/core/ucdc_pkg.sv]
// Shared types, codes and descriptor ROM for the CDC-ACM endpoint-0 handler.
// No dependencies.
`timescale 1ns / 1ps

package ucdc_pkg;

  localparam int unsigned PacketMax  = 64;
  localparam int unsigned ReplyDepth = 7;
  localparam int unsigned ReplyAw    = $clog2(ReplyDepth);
  localparam int unsigned RomDepth   = 159;

  // events
  localparam logic [1:0] CMD_SETUP   = 2'd0;
  localparam logic [1:0] CMD_IN_DONE = 2'd1;
  localparam logic [1:0] CMD_OUT_DONE = 2'd2;
  localparam logic [1:0] CMD_BUS_RST = 2'd3;

  // actions
  localparam logic [3:0] ACT_BYTE       = 4'd0;
  localparam logic [3:0] ACT_ZLP        = 4'd1;
  localparam logic [3:0] ACT_STALL      = 4'd2;
  localparam logic [3:0] ACT_ARM        = 4'd3;
  localparam logic [3:0] ACT_ADDR       = 4'd4;
  localparam logic [3:0] ACT_HALT       = 4'd5;
  localparam logic [3:0] ACT_UNHALT     = 4'd6;
  localparam logic [3:0] ACT_OPEN_DATA  = 4'd7;
  localparam logic [3:0] ACT_CLOSE_DATA = 4'd8;
  localparam logic [3:0] ACT_OPEN_CTRL  = 4'd9;

  // request types (bits 6:5 of bmRequestType) and recipients (bits 4:0)
  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_CLASS    = 2'd1;
  localparam logic [4:0] RCP_IFACE   = 5'h01;
  localparam logic [4:0] RCP_EP      = 5'h02;

  // standard requests
  localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] REQ_CLR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE   = 8'h0A;
  localparam logic [7:0] REQ_SET_IFACE   = 8'h0B;
  // class requests
  localparam logic [7:0] REQ_SET_LINE    = 8'h20;
  localparam logic [7:0] REQ_GET_LINE    = 8'h21;
  localparam logic [7:0] REQ_SET_CTRL    = 8'h22;

  // IN data sources
  localparam logic [2:0] SRC_NONE   = 3'd0;
  localparam logic [2:0] SRC_DEVICE = 3'd1;
  localparam logic [2:0] SRC_CONFIG = 3'd2;
  localparam logic [2:0] SRC_STR0   = 3'd3;
  localparam logic [2:0] SRC_REPLY  = 3'd7;

  localparam logic [31:0] BaudReset     = 32'd115200;
  localparam logic [7:0]  DataBitsReset = 8'd8;

  typedef struct packed {
    logic        out_pending;
    logic [2:0]  in_source;
    logic [6:0]  in_offset;
    logic [6:0]  in_remaining;
    logic        cur_config;
    logic [7:0]  cur_iface;
    logic [7:0]  line_state;
    logic [31:0] baud;
    logic [7:0]  stop;
    logic [7:0]  parity;
    logic [7:0]  data_bits;
    logic        is_configured;
    logic        zlp_owed;
  } ctl_t;

  typedef struct packed {
    logic [3:0] act;
    logic [7:0] arg;
  } act_t;

  typedef struct packed {
    act_t [2:0]  acts;
    logic [1:0]  n_act;
    logic [6:0]  n_bytes;
    logic [6:0]  pkt_off;
    logic [2:0]  pkt_src;
    logic [2:0]  n_wr;
    logic [55:0] wr_data;
  } plan_t;

  localparam logic [7:0] Rom [RomDepth] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'h02, 8'h02, 8'h00, 8'h40, 8'h83, 8'h04, 8'h40, 8'h57,
    8'h00, 8'h02, 8'h01, 8'h02, 8'h03, 8'h01,
    8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h01, 8'h00,
    8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
    8'h05, 8'h24, 8'h01, 8'h00, 8'h01,
    8'h04, 8'h24, 8'h02, 8'h02,
    8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
    8'h07, 8'h05, 8'h82, 8'h03, 8'h08, 8'h00, 8'h10,
    8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
    8'h04, 8'h03, 8'h09, 8'h04,
    8'h0A, 8'h03, 8'h69, 8'h00, 8'h46, 8'h00, 8'h6C, 8'h00, 8'h79, 8'h00,
    8'h22, 8'h03, 8'h69, 8'h00, 8'h46, 8'h00, 8'h6C, 8'h00, 8'h79, 8'h00, 8'h20, 8'h00,
    8'h55, 8'h00, 8'h53, 8'h00, 8'h42, 8'h00, 8'h20, 8'h00, 8'h43, 8'h00, 8'h44, 8'h00,
    8'h43, 8'h00, 8'h20, 8'h00, 8'h41, 8'h00, 8'h43, 8'h00, 8'h4D, 8'h00,
    8'h1A, 8'h03, 8'h49, 8'h00, 8'h46, 8'h00, 8'h4C, 8'h00, 8'h59, 8'h00, 8'h30, 8'h00,
    8'h30, 8'h00, 8'h30, 8'h00, 8'h31, 8'h00, 8'h32, 8'h00, 8'h30, 8'h00, 8'h32, 8'h00,
    8'h36, 8'h00
  };

  function automatic logic [7:0] rom_byte(input logic [7:0] addr);
    rom_byte = (addr < 8'(RomDepth)) ? Rom[addr] : 8'h00;
  endfunction

  function automatic logic [7:0] src_base(input logic [2:0] src);
    unique case (src)
      3'd2:    src_base = 8'd18;
      3'd3:    src_base = 8'd85;
      3'd4:    src_base = 8'd89;
      3'd5:    src_base = 8'd99;
      3'd6:    src_base = 8'd133;
      default: src_base = 8'd0;
    endcase
  endfunction

  function automatic logic [6:0] src_len(input logic [2:0] src);
    unique case (src)
      3'd1:    src_len = 7'd18;
      3'd2:    src_len = 7'd67;
      3'd3:    src_len = 7'd4;
      3'd4:    src_len = 7'd10;
      3'd5:    src_len = 7'd34;
      3'd6:    src_len = 7'd26;
      3'd7:    src_len = 7'd7;
      default: src_len = 7'd0;
    endcase
  endfunction

endpackage

[rtl/core/ucdc_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ucdc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ucdc_decode.sv]
// Event decoder: next control state and the action plan for one event.
// Depends on ucdc_pkg.
`timescale 1ns / 1ps

module ucdc_decode import ucdc_pkg::*; (
  input  logic [1:0]   cmd_i,
  input  logic [7:0]   rt_i,
  input  logic [7:0]   code_i,
  input  logic [15:0]  val_i,
  input  logic [15:0]  idx_i,
  input  logic [15:0]  len_i,
  input  logic [6:0]   cnt_i,
  input  logic [55:0]  pay_i,
  input  ctl_t         st_i,
  output ctl_t         st_o,
  output plan_t        plan_o
);

  always_comb begin
    ctl_t       ns;
    plan_t      pl;
    logic [2:0] src;
    logic [6:0] slen;
    logic [6:0] actual;
    logic [6:0] chunk;
    logic       do_in;
    logic [7:0] lo;

    ns     = st_i;
    pl     = '0;
    src    = SRC_NONE;
    slen   = '0;
    actual = '0;
    chunk  = '0;
    do_in  = 1'b0;
    lo     = val_i[7:0];

    unique case (cmd_i)
      CMD_SETUP: begin
        ns.out_pending  = 1'b0;
        ns.in_source    = SRC_NONE;
        ns.in_offset    = '0;
        ns.in_remaining = '0;
        ns.zlp_owed     = 1'b0;
        pl.acts[0]      = '{act: ACT_STALL, arg: 8'd0};
        pl.n_act        = 2'd1;
        if (rt_i[6:5] == RT_STANDARD) begin
          unique case (code_i)
            REQ_GET_DESC: begin
              if (val_i[15:8] == 8'd1) src = SRC_DEVICE;
              else if (val_i[15:8] == 8'd2) src = SRC_CONFIG;
              else if (val_i[15:8] == 8'd3 && lo <= 8'd3) src = SRC_STR0 + lo[2:0];
              if (src != SRC_NONE) begin
                do_in = 1'b1;
                slen  = src_len(src);
              end
            end
            REQ_SET_ADDRESS: begin
              pl.acts[0] = '{act: ACT_ADDR, arg: {1'b0, val_i[6:0]}};
              pl.acts[1] = '{act: ACT_ZLP, arg: 8'd0};
              pl.n_act   = 2'd2;
            end
            REQ_GET_CONFIG: begin
              pl.wr_data = {48'd0, 7'd0, st_i.cur_config};
              pl.n_wr    = 3'd1;
              src = SRC_REPLY; slen = 7'd1; do_in = 1'b1;
            end
            REQ_SET_CONFIG: begin
              if (lo <= 8'd1) begin
                ns.cur_config    = lo[0];
                ns.is_configured = lo[0];
                pl.acts[0] = '{act: ACT_CLOSE_DATA, arg: 8'd0};
                if (lo[0]) begin
                  pl.acts[1] = '{act: ACT_OPEN_DATA, arg: 8'd0};
                  pl.acts[2] = '{act: ACT_ZLP, arg: 8'd0};
                  pl.n_act   = 2'd3;
                end else begin
                  pl.acts[1] = '{act: ACT_ZLP, arg: 8'd0};
                  pl.n_act   = 2'd2;
                end
              end
            end
            REQ_GET_IFACE: begin
              pl.wr_data = {48'd0, st_i.cur_iface};
              pl.n_wr    = 3'd1;
              src = SRC_REPLY; slen = 7'd1; do_in = 1'b1;
            end
            REQ_SET_IFACE: begin
              ns.cur_iface = lo;
              pl.acts[0]   = '{act: ACT_ZLP, arg: 8'd0};
            end
            REQ_GET_STATUS: begin
              pl.wr_data = '0;
              pl.n_wr    = 3'd2;
              src = SRC_REPLY; slen = 7'd2; do_in = 1'b1;
            end
            REQ_CLR_FEATURE, REQ_SET_FEATURE: begin
              if (rt_i[4:0] == RCP_EP && val_i == 16'd0) begin
                pl.acts[0] = '{act: (code_i == REQ_SET_FEATURE) ? ACT_HALT : ACT_UNHALT,
                               arg: idx_i[7:0]};
                pl.acts[1] = '{act: ACT_ZLP, arg: 8'd0};
                pl.n_act   = 2'd2;
              end
            end
            default: ;
          endcase
        end else if (rt_i[6:5] == RT_CLASS && rt_i[4:0] == RCP_IFACE) begin
          unique case (code_i)
            REQ_SET_LINE: begin
              if (len_i == 16'd7) begin
                ns.out_pending = 1'b1;
                pl.acts[0] = '{act: ACT_ARM, arg: 8'd7};
              end
            end
            REQ_GET_LINE: begin
              pl.wr_data = {st_i.data_bits, st_i.parity, st_i.stop, st_i.baud};
              pl.n_wr    = 3'd7;
              src = SRC_REPLY; slen = 7'd7; do_in = 1'b1;
            end
            REQ_SET_CTRL: begin
              ns.line_state = lo;
              pl.acts[0]    = '{act: ACT_ZLP, arg: 8'd0};
            end
            default: ;
          endcase
        end
        if (do_in) begin
          actual       = ({9'd0, slen} < len_i) ? slen : len_i[6:0];
          ns.in_source = src;
          ns.zlp_owed  = (actual != 7'd0) && ({9'd0, actual} < len_i) &&
                         ((actual % PacketMax) == 7'd0);
          if (actual == 7'd0) begin
            pl.acts[0] = '{act: ACT_ZLP, arg: 8'd0};
            pl.n_act   = 2'd1;
          end else begin
            chunk           = (actual > 7'(PacketMax)) ? 7'(PacketMax) : actual;
            pl.n_act        = 2'd0;
            pl.n_bytes      = chunk;
            pl.pkt_off      = 7'd0;
            pl.pkt_src      = src;
            ns.in_offset    = chunk;
            ns.in_remaining = actual - chunk;
          end
        end
      end
      CMD_IN_DONE: begin
        pl.n_act = 2'd1;
        if (st_i.in_remaining != 7'd0) begin
          chunk = (st_i.in_remaining > 7'(PacketMax)) ? 7'(PacketMax) : st_i.in_remaining;
          pl.n_act        = 2'd0;
          pl.n_bytes      = chunk;
          pl.pkt_off      = st_i.in_offset;
          pl.pkt_src      = st_i.in_source;
          ns.in_offset    = st_i.in_offset + chunk;
          ns.in_remaining = st_i.in_remaining - chunk;
        end else if (st_i.zlp_owed) begin
          ns.zlp_owed  = 1'b0;
          ns.in_source = SRC_NONE;
          pl.acts[0]   = '{act: ACT_ZLP, arg: 8'd0};
        end else begin
          ns.in_source = SRC_NONE;
          ns.in_offset = '0;
          pl.acts[0]   = '{act: ACT_ARM, arg: 8'd0};
        end
      end
      CMD_OUT_DONE: begin
        if (st_i.out_pending) begin
          ns.out_pending = 1'b0;
          pl.n_act       = 2'd1;
          if (cnt_i >= 7'd7) begin
            ns.baud      = pay_i[31:0];
            ns.stop      = pay_i[39:32];
            ns.parity    = pay_i[47:40];
            ns.data_bits = pay_i[55:48];
            pl.acts[0]   = '{act: ACT_ZLP, arg: 8'd0};
          end else begin
            pl.acts[0]   = '{act: ACT_STALL, arg: 8'd0};
          end
        end
      end
      CMD_BUS_RST: begin
        ns           = '0;
        ns.baud      = BaudReset;
        ns.data_bits = DataBitsReset;
        pl.acts[0]   = '{act: ACT_ADDR, arg: 8'd0};
        pl.acts[1]   = '{act: ACT_OPEN_CTRL, arg: 8'd0};
        pl.n_act     = 2'd2;
      end
      default: ;
    endcase

    st_o   = ns;
    plan_o = pl;
  end

endmodule

[rtl/core/usb_cdc_control_endpoint_unit.sv]
// Top level of the CDC-ACM endpoint-0 control handler.
// Depends on ucdc_pkg, ucdc_decode and ucdc_ram.
`timescale 1ns / 1ps

// Usage
// - Slave channel: one beat per endpoint-0 event (setup, IN done, OUT done,
//   bus reset). Event code on tuser, setup fields and OUT data on tdata.
// - Master channel: one beat per action; action code on tuser, tlast marks
//   the final action of an event. Each beat also carries the device state
//   (configured, control lines, line coding) as it stands after the event.
// - An event is decoded in the cycle it is accepted. Reply data for status,
//   configuration, interface and line-coding requests is first written into
//   a 7-entry reply RAM, one byte a cycle. Plain actions then leave at one
//   beat a cycle while the output is not stalled; each IN packet byte is
//   first read from the RAM or ROM, then loaded into the output register.
// - One event is handled at a time; s_axis_tready_o is high only while no
//   actions of an earlier event are left to issue. The final action may
//   still wait in the output register while the next event is accepted.
// - A stall on m_axis_tready_i simply holds the output register and the
//   sequencer; nothing is dropped.
// - Reset clears all control state, line coding returns to 115200 8N1 style
//   defaults. The reply RAM needs no clearing: it is always written before
//   it is read.
module usb_cdc_control_endpoint_unit import ucdc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // request_type, request_code, request_value, request_index,
  // request_length, out_count, out_payload, 1 pad bit
  input  logic [127:0] s_axis_tdata_i,
  // cmd
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // data_byte, action_argument, configured, control_lines, baud_rate,
  // stop_bits, parity, data_bits, 7 pad bits
  output logic [87:0]  m_axis_tdata_o,
  // action
  output logic [3:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_ACTS  = 5'b00100,
    S_READ  = 5'b01000,
    S_BYTE  = 5'b10000
  } state_e;

  state_e       state_q, state_d;
  ctl_t         ctl_q, ctl_next;
  plan_t        plan_q, plan_dec;
  logic [2:0]   wr_idx_q, wr_idx_d;
  logic [1:0]   act_idx_q, act_idx_d;
  logic [6:0]   off_q, off_d;
  logic [6:0]   left_q, left_d;
  logic [7:0]   rom_q;
  logic [7:0]   ram_rdata;
  logic         ram_we;
  logic         in_fire;
  logic         out_free;

  logic         out_valid_q, out_valid_d;
  logic [87:0]  out_data_q, out_data_d;
  logic [3:0]   out_act_q, out_act_d;
  logic         out_last_q, out_last_d;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  ucdc_decode u_decode (
    .cmd_i  (s_axis_tuser_i),
    .rt_i   (s_axis_tdata_i[7:0]),
    .code_i (s_axis_tdata_i[15:8]),
    .val_i  (s_axis_tdata_i[31:16]),
    .idx_i  (s_axis_tdata_i[47:32]),
    .len_i  (s_axis_tdata_i[63:48]),
    .cnt_i  (s_axis_tdata_i[70:64]),
    .pay_i  (s_axis_tdata_i[126:71]),
    .st_i   (ctl_q),
    .st_o   (ctl_next),
    .plan_o (plan_dec)
  );

  assign ram_we = (state_q == S_WRITE);

  ucdc_ram #(
    .Width (8),
    .Depth (ReplyDepth)
  ) u_reply_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q[ReplyAw-1:0]),
    .wdata_i (plan_q.wr_data[8*wr_idx_q +: 8]),
    .raddr_i (off_q[ReplyAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // descriptor ROM read, registered like the RAM
  always_ff @(posedge clk_i) begin
    rom_q <= rom_byte(src_base(plan_q.pkt_src) + {1'b0, off_q});
  end

  // payload of one result beat: state after the event, per-action fields
  function automatic logic [87:0] beat_data(input ctl_t c, input logic [7:0] b,
                                            input logic [7:0] a);
    beat_data = {7'd0, c.data_bits, c.parity, c.stop, c.baud, c.line_state,
                 c.is_configured, a, b};
  endfunction

  always_comb begin
    state_d     = state_q;
    wr_idx_d    = wr_idx_q;
    act_idx_d   = act_idx_q;
    off_d       = off_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_act_d   = out_act_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          wr_idx_d  = '0;
          act_idx_d = '0;
          off_d     = plan_dec.pkt_off;
          left_d    = plan_dec.n_bytes;
          if (plan_dec.n_wr != 3'd0) state_d = S_WRITE;
          else if (plan_dec.n_act != 2'd0) state_d = S_ACTS;
          else if (plan_dec.n_bytes != 7'd0) state_d = S_READ;
        end
      end
      S_WRITE: begin
        wr_idx_d = wr_idx_q + 3'd1;
        if (wr_idx_q == plan_q.n_wr - 3'd1) begin
          if (plan_q.n_act != 2'd0) state_d = S_ACTS;
          else if (plan_q.n_bytes != 7'd0) state_d = S_READ;
          else state_d = S_IDLE;
        end
      end
      S_ACTS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_act_d   = plan_q.acts[act_idx_q].act;
          out_data_d  = beat_data(ctl_q, 8'd0, plan_q.acts[act_idx_q].arg);
          out_last_d  = (act_idx_q == plan_q.n_act - 2'd1);
          act_idx_d   = act_idx_q + 2'd1;
          if (act_idx_q == plan_q.n_act - 2'd1) state_d = S_IDLE;
        end
      end
      S_READ: begin
        state_d = S_BYTE;
      end
      S_BYTE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_act_d   = ACT_BYTE;
          out_data_d  = beat_data(ctl_q,
                                  (plan_q.pkt_src == SRC_REPLY) ? ram_rdata : rom_q, 8'd0);
          out_last_d  = (left_q == 7'd1);
          off_d       = off_q + 7'd1;
          left_d      = left_q - 7'd1;
          state_d     = (left_q == 7'd1) ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ctl_q          <= '0;
      ctl_q.baud     <= BaudReset;
      ctl_q.data_bits <= DataBitsReset;
      out_valid_q    <= 1'b0;
      wr_idx_q       <= '0;
      act_idx_q      <= '0;
      left_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wr_idx_q    <= wr_idx_d;
      act_idx_q   <= act_idx_d;
      left_q      <= left_d;
      if (in_fire) begin
        ctl_q <= ctl_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    off_q      <= off_d;
    out_data_q <= out_data_d;
    out_act_q  <= out_act_d;
    out_last_q <= out_last_d;
    if (in_fire) begin
      plan_q <= plan_dec;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_act_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
